// ----- design/hrrn_pkg.sv -----
// Shared types and constants for the response-ratio ready queue.
`default_nettype none
package hrrn_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int ID_W          = 8;
  localparam int LEN_W         = 16;
  localparam int OCC_W         = 5;

  typedef enum logic [2:0] {
    CMD_ENQ    = 3'd0,
    CMD_DEQ    = 3'd1,
    CMD_TAKE   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_SET    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] burst;
    logic [LEN_W-1:0] wait_len;
  } entry_t;

  typedef struct packed {
    logic load;
    logic first;
  } sel_ctl_t;

endpackage
`default_nettype wire

// ----- design/hrrn_if.sv -----
// Valid/ready channel interfaces for commands and responses.
`default_nettype none
interface hrrn_cmd_if import hrrn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       cmd;
  logic [ID_W-1:0]  proc_id;
  logic [LEN_W-1:0] burst_len;
  logic [LEN_W-1:0] wait_len;

  modport source (output valid, cmd, proc_id, burst_len, wait_len, input ready);
  modport sink (input valid, cmd, proc_id, burst_len, wait_len, output ready);
endinterface

interface hrrn_rsp_if import hrrn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  out_id;
  logic [LEN_W-1:0] out_burst;
  logic [LEN_W-1:0] out_wait;
  logic [OCC_W-1:0] occupancy;
  logic             is_empty_flag;

  modport source (output valid, status, out_id, out_burst, out_wait, occupancy,
                  is_empty_flag, input ready);
  modport sink (input valid, status, out_id, out_burst, out_wait, occupancy,
                is_empty_flag, output ready);
endinterface
`default_nettype wire

// ----- design/hrrn_entry_ram.sv -----
// Entry memory: one write port and one registered read port.
`default_nettype none
module hrrn_entry_ram
  import hrrn_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           wr_en,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
  input  wire entry_t                         wr_data,
  input  wire logic                           rd_en,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
  output entry_t                              rd_data
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- design/hrrn_ratio_sel.sv -----
// Running best-ratio selector fed one entry per cycle during a scan.
`default_nettype none
module hrrn_ratio_sel
  import hrrn_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic                           clk,
  input  wire sel_ctl_t                       ctl,
  input  wire logic [$clog2(QUEUE_DEPTH)-1:0] idx,
  input  wire entry_t                         cand,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      best_idx,
  output entry_t                              best_entry
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [LEN_W-1:0]   best_b;
  logic [LEN_W:0]     best_n;
  logic [LEN_W-1:0]   cand_b;
  logic [LEN_W:0]     cand_n;
  logic [2*LEN_W:0]   lhs;
  logic [2*LEN_W:0]   rhs;
  logic               better;

  // A burst of zero counts as one; the earlier entry keeps a tie.
  always_comb begin
    cand_b = (cand.burst == '0) ? LEN_W'(1) : cand.burst;
    cand_n = {1'b0, cand.wait_len} + {1'b0, cand_b};
    lhs    = cand_n * best_b;
    rhs    = best_n * cand_b;
    better = lhs > rhs;
  end

  always_ff @(posedge clk) begin
    if (ctl.load && (ctl.first || better)) begin
      best_idx   <= AW'(idx);
      best_entry <= cand;
      best_b     <= cand_b;
      best_n     <= cand_n;
    end
  end

endmodule
`default_nettype wire

// ----- design/hrrn_ready_queue_core.sv -----
// Top level of the ready queue ordered by arrival with highest-response-ratio take.
//
// Commands arrive on cmd_ch and each produces exactly one response on rsp_ch,
// both valid/ready channels; a transfer happens when valid and ready are high.
// Entries live in a single-port-read, single-port-write memory with a registered
// read port, and one command is worked at a time.
// Enqueue, unused codes and commands on an empty queue go from accept straight
// to the done state. Dequeue, remove and set walk the queue one entry per cycle
// until the match or the end; take-highest-ratio reads all N entries through one
// shared cross-multiply compare. Removal then closes the gap by moving each later
// entry down, one per cycle.
// The response sits in an output register, so a new command is accepted
// while an earlier response waits; if the receiver stalls, the next finished
// response holds in the done state and no further command is taken.
// Synchronous reset empties the queue; the memory itself is not cleared.
`default_nettype none
module hrrn_ready_queue_core
  import hrrn_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hrrn_cmd_if.sink    cmd_ch,
  hrrn_rsp_if.source  rsp_ch
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t           state, state_next;
  logic [CW-1:0]    count, count_next;
  logic             issue_on, issue_on_next;
  logic [AW-1:0]    issue_idx, issue_idx_next;
  logic             rd_pend;
  logic [AW-1:0]    rd_idx_q;
  cmd_t             cmd_q, cmd_next;
  logic [ID_W-1:0]  id_q, id_next;
  logic [LEN_W-1:0] wait_q, wait_next;
  status_t          res_status, res_status_next;
  entry_t           res_entry, res_entry_next;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  entry_t           wr_data;
  sel_ctl_t         sel_ctl;
  logic [AW-1:0]    best_idx;
  entry_t           best_entry;

  cmd_t             cmd_in;
  logic [AW-1:0]    last_idx;
  logic             rd_last;
  logic             hit;
  logic             scan_stop;
  logic             rsp_load;
  logic             rsp_valid;
  status_t          rsp_status;
  entry_t           rsp_entry;
  logic [OCC_W-1:0] rsp_occ;
  logic             rsp_empty;

  hrrn_entry_ram #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hrrn_ratio_sel #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_sel (
    .clk        (clk),
    .ctl        (sel_ctl),
    .idx        (rd_idx_q),
    .cand       (rd_data),
    .best_idx   (best_idx),
    .best_entry (best_entry)
  );

  assign cmd_in   = cmd_t'(cmd_ch.cmd);
  assign last_idx = AW'(count - CW'(1));
  assign rd_last  = rd_idx_q == last_idx;
  assign hit      = (cmd_q == CMD_DEQ) ||
                    (((cmd_q == CMD_REMOVE) || (cmd_q == CMD_SET)) && (rd_data.id == id_q));
  assign scan_stop = rd_pend && (hit || rd_last);

  assign cmd_ch.ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      issue_on <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      issue_on <= issue_on_next;
      rd_pend  <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx  <= issue_idx_next;
    rd_idx_q   <= rd_addr;
    cmd_q      <= cmd_next;
    id_q       <= id_next;
    wait_q     <= wait_next;
    res_status <= res_status_next;
    res_entry  <= res_entry_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    issue_on_next   = issue_on;
    issue_idx_next  = issue_idx;
    cmd_next        = cmd_q;
    id_next         = id_q;
    wait_next       = wait_q;
    res_status_next = res_status;
    res_entry_next  = res_entry;
    rd_en           = 1'b0;
    rd_addr         = issue_idx;
    wr_en           = 1'b0;
    wr_addr         = rd_idx_q;
    wr_data         = rd_data;
    sel_ctl         = '0;
    rsp_load        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (cmd_ch.valid) begin
          cmd_next        = cmd_in;
          id_next         = cmd_ch.proc_id;
          wait_next       = cmd_ch.wait_len;
          res_status_next = ST_OK;
          res_entry_next  = '0;
          issue_idx_next  = '0;
          issue_on_next   = 1'b1;
          state_next      = S_DONE;
          unique case (cmd_in) inside
            CMD_ENQ: begin
              if (count == CW'(QUEUE_DEPTH)) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count);
                wr_data    = '{id: cmd_ch.proc_id, burst: cmd_ch.burst_len,
                               wait_len: cmd_ch.wait_len};
                count_next = count + CW'(1);
              end
            end
            CMD_DEQ, CMD_TAKE, CMD_REMOVE, CMD_SET: begin
              if (count == '0) begin
                res_status_next = ST_MISS;
              end else begin
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue_on && !scan_stop) begin
          rd_en = 1'b1;
          if (issue_idx == last_idx) begin
            issue_on_next = 1'b0;
          end else begin
            issue_idx_next = issue_idx + AW'(1);
          end
        end
        if (rd_pend) begin
          if (cmd_q == CMD_TAKE) begin
            sel_ctl.load  = 1'b1;
            sel_ctl.first = rd_idx_q == '0;
            if (rd_last) begin
              state_next = S_PICK;
            end
          end else if (hit) begin
            if (cmd_q == CMD_SET) begin
              wr_en            = 1'b1;
              wr_addr          = rd_idx_q;
              wr_data          = rd_data;
              wr_data.wait_len = wait_q;
              state_next       = S_DONE;
            end else begin
              res_entry_next = rd_data;
              if (rd_idx_q == last_idx) begin
                count_next = count - CW'(1);
                state_next = S_DONE;
              end else begin
                issue_idx_next = rd_idx_q + AW'(1);
                issue_on_next  = 1'b1;
                state_next     = S_SHIFT;
              end
            end
          end else if (rd_last) begin
            res_status_next = ST_MISS;
            state_next      = S_DONE;
          end
        end
      end
      S_PICK: begin
        res_entry_next = best_entry;
        if (best_idx == last_idx) begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end else begin
          issue_idx_next = best_idx + AW'(1);
          issue_on_next  = 1'b1;
          state_next     = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (issue_on) begin
          rd_en = 1'b1;
          if (issue_idx == last_idx) begin
            issue_on_next = 1'b0;
          end else begin
            issue_idx_next = issue_idx + AW'(1);
          end
        end
        if (rd_pend) begin
          wr_en   = 1'b1;
          wr_addr = rd_idx_q - AW'(1);
          wr_data = rd_data;
          if (rd_last) begin
            count_next = count - CW'(1);
            state_next = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ch.ready) begin
          rsp_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_status <= res_status;
      rsp_entry  <= res_entry;
      rsp_occ    <= OCC_W'(count);
      rsp_empty  <= count == '0;
    end
  end

  assign rsp_ch.valid         = rsp_valid;
  assign rsp_ch.status        = rsp_status;
  assign rsp_ch.out_id        = rsp_entry.id;
  assign rsp_ch.out_burst     = rsp_entry.burst;
  assign rsp_ch.out_wait      = rsp_entry.wait_len;
  assign rsp_ch.occupancy     = rsp_occ;
  assign rsp_ch.is_empty_flag = rsp_empty;

  // The queue never holds more entries than it has places.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // Read data is only ever returned into a state that consumes it.
  a_read_consumed: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN || state == S_SHIFT))
    else $error("memory read returned outside a scan or shift");

  // One command moves the entry count by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count == $past(count) - CW'(1)))
    else $error("entry count jumped by more than one");

  // A response is loaded only when the output register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || rsp_ch.ready))
    else $error("pending response overwritten");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the response-ratio ready queue, checked against its own queue model.
`timescale 1ns / 100ps
module tb_top
  import hrrn_pkg::*;
();

  localparam int QDEPTH = DEFAULT_DEPTH;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 2 * QDEPTH + 16;
  localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  id;
    logic [LEN_W-1:0] burst;
    logic [LEN_W-1:0] wait_len;
    logic [OCC_W-1:0] occupancy;
    logic             empty;
  } rsp_t;

  logic clk;
  logic rst;

  hrrn_cmd_if cmd_ch ();
  hrrn_rsp_if rsp_ch ();

  hrrn_ready_queue_core #(.QUEUE_DEPTH(QDEPTH)) u_top (
    .clk   (clk),
    .rst   (rst),
    .cmd_ch(cmd_ch),
    .rsp_ch(rsp_ch)
  );

  logic [ID_W-1:0]  mdl_id    [QDEPTH];
  logic [LEN_W-1:0] mdl_burst [QDEPTH];
  logic [LEN_W-1:0] mdl_wait  [QDEPTH];
  int               mdl_count;
  rsp_t             pending_rsps[$];
  int               err_count;
  int               src_idle_pct;
  int               sink_idle_pct;
  bit               draining;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int find_entry(input logic [ID_W-1:0] pid);
    for (int i = 0; i < mdl_count; i++) begin
      if (mdl_id[i] == pid) return i;
    end
    return -1;
  endfunction

  function automatic void remove_entry(input int pos, inout rsp_t r);
    r.id = mdl_id[pos];
    r.burst = mdl_burst[pos];
    r.wait_len = mdl_wait[pos];
    for (int i = pos; i + 1 < mdl_count; i++) begin
      mdl_id[i] = mdl_id[i + 1];
      mdl_burst[i] = mdl_burst[i + 1];
      mdl_wait[i] = mdl_wait[i + 1];
    end
    mdl_count--;
  endfunction

  function automatic rsp_t apply_cmd_to_model(input logic [2:0] op, input logic [ID_W-1:0] pid,
                                               input logic [LEN_W-1:0] burst,
                                               input logic [LEN_W-1:0] wlen);
    rsp_t        r;
    int          pos;
    logic [63:0] best_n;
    logic [63:0] best_b;
    logic [63:0] n;
    logic [63:0] b;
    r.status = ST_OK;
    r.id = '0;
    r.burst = '0;
    r.wait_len = '0;
    case (op)
      CMD_ENQ: begin
        if (mdl_count >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          mdl_id[mdl_count] = pid;
          mdl_burst[mdl_count] = burst;
          mdl_wait[mdl_count] = wlen;
          mdl_count++;
        end
      end
      CMD_DEQ: begin
        if (mdl_count == 0) r.status = ST_MISS;
        else remove_entry(0, r);
      end
      CMD_TAKE: begin
        if (mdl_count == 0) begin
          r.status = ST_MISS;
        end else begin
          // Ratios are compared by cross multiplication; a zero burst counts as one.
          pos = 0;
          best_b = (mdl_burst[0] == '0) ? 64'd1 : 64'(mdl_burst[0]);
          best_n = 64'(mdl_wait[0]) + best_b;
          for (int i = 1; i < mdl_count; i++) begin
            b = (mdl_burst[i] == '0) ? 64'd1 : 64'(mdl_burst[i]);
            n = 64'(mdl_wait[i]) + b;
            if (n * best_b > best_n * b) begin
              pos = i;
              best_b = b;
              best_n = n;
            end
          end
          remove_entry(pos, r);
        end
      end
      CMD_REMOVE: begin
        pos = find_entry(pid);
        if (pos < 0) r.status = ST_MISS;
        else remove_entry(pos, r);
      end
      CMD_SET: begin
        pos = find_entry(pid);
        if (pos < 0) r.status = ST_MISS;
        else mdl_wait[pos] = wlen;
      end
      default: begin
      end
    endcase
    r.occupancy = OCC_W'(mdl_count);
    r.empty = (mdl_count == 0);
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return LEN_W'($urandom_range(1, 64));
      default: return LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
  endtask

  task automatic send_cmd(input logic [2:0] op, input logic [ID_W-1:0] pid,
                          input logic [LEN_W-1:0] burst, input logic [LEN_W-1:0] wlen);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd <= op;
    cmd_ch.proc_id <= pid;
    cmd_ch.burst_len <= burst;
    cmd_ch.wait_len <= wlen;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    pending_rsps.push_back(apply_cmd_to_model(op, pid, burst, wlen));
  endtask

  task automatic test_empty_queue();
    send_cmd(CMD_DEQ, 8'd0, 16'd0, 16'd0);
    send_cmd(CMD_TAKE, 8'd0, 16'd0, 16'd0);
    send_cmd(CMD_REMOVE, 8'd5, 16'd0, 16'd0);
    send_cmd(CMD_SET, 8'd5, 16'd0, 16'd77);
    send_cmd(CMD_UNUSED_HI, 8'hff, 16'hffff, 16'hffff);
  endtask

  task automatic test_fill_and_overflow();
    send_cmd(CMD_ENQ, 8'd255, 16'd0, 16'hffff);
    send_cmd(CMD_ENQ, 8'd0, 16'hffff, 16'd0);
    send_cmd(CMD_ENQ, 8'd7, 16'd1, 16'd0);
    send_cmd(CMD_ENQ, 8'd7, 16'd0, 16'hffff);
    for (int i = 4; i < QDEPTH; i++) begin
      send_cmd(CMD_ENQ, ID_W'(16 + i), LEN_W'(1000 + i), LEN_W'(i));
    end
    send_cmd(CMD_ENQ, 8'd200, 16'd5, 16'd5);
  endtask

  task automatic test_lookup_and_ties();
    send_cmd(CMD_SET, 8'd7, 16'd0, 16'd9);
    send_cmd(CMD_REMOVE, 8'd7, 16'd0, 16'd0);
    send_cmd(CMD_REMOVE, 8'd99, 16'd0, 16'd0);
    send_cmd(CMD_TAKE, 8'd0, 16'd0, 16'd0);
    send_cmd(CMD_TAKE, 8'd0, 16'd0, 16'd0);
    send_cmd(CMD_DEQ, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic test_random_traffic(input int n_items);
    int              pick;
    logic [2:0]      op;
    logic [ID_W-1:0] pid;
    for (int k = 0; k < n_items; k++) begin
      // Alternate between filling and draining so that every fill level is visited.
      if (mdl_count == 0) draining = 1'b0;
      else if (mdl_count == QDEPTH && $urandom_range(0, 2) == 0) draining = 1'b1;
      else if ($urandom_range(0, 99) < 3) draining = !draining;
      pick = $urandom_range(0, 99);
      if (pick < 5) op = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
      else if (pick < (draining ? 20 : 60)) op = CMD_ENQ;
      else if (pick < (draining ? 40 : 68)) op = CMD_DEQ;
      else if (pick < (draining ? 70 : 80)) op = CMD_TAKE;
      else if (pick < 90) op = CMD_REMOVE;
      else op = CMD_SET;
      if ((op == CMD_REMOVE || op == CMD_SET) && mdl_count != 0 && $urandom_range(0, 99) < 75)
        pid = mdl_id[$urandom_range(0, mdl_count - 1)];
      else
        pid = ($urandom_range(0, 99) < 70) ? ID_W'($urandom_range(0, 15))
                                           : ID_W'($urandom_range(0, 255));
      send_cmd(op, pid, random_len(), random_len());
    end
  endtask

  initial begin : rsp_checker
    rsp_t exp_rsp;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        if (pending_rsps.size() == 0) begin
          report_mismatch("response transfer with no response expected");
        end else begin
          exp_rsp = pending_rsps.pop_front();
          check_field("status", 32'(rsp_ch.status), 32'(exp_rsp.status));
          check_field("out_id", 32'(rsp_ch.out_id), 32'(exp_rsp.id));
          check_field("out_burst", 32'(rsp_ch.out_burst), 32'(exp_rsp.burst));
          check_field("out_wait", 32'(rsp_ch.out_wait), 32'(exp_rsp.wait_len));
          check_field("occupancy", 32'(rsp_ch.occupancy), 32'(exp_rsp.occupancy));
          check_field("is_empty_flag", 32'(rsp_ch.is_empty_flag), 32'(exp_rsp.empty));
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    err_count = 0;
    mdl_count = 0;
    draining = 1'b0;
    src_idle_pct = 34;
    sink_idle_pct = 75;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.cmd <= CMD_ENQ;
    cmd_ch.proc_id <= '0;
    cmd_ch.burst_len <= '0;
    cmd_ch.wait_len <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_fill_and_overflow();
    test_lookup_and_ties();
    test_random_traffic(460);

    src_idle_pct = 75;
    sink_idle_pct = 34;
    test_random_traffic(500);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(500);

    cmd_ch.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/hrrn_pkg.sv
design/hrrn_if.sv
design/hrrn_entry_ram.sv
design/hrrn_ratio_sel.sv
design/hrrn_ready_queue_core.sv
bench/tb_top.sv
